/* design/rfc_ecs_pkg.sv */
// ----------------------------------------------------------------------------
// rfc_ecs_pkg: shared types and constants of the equivalence-class store
// Sizes of the stores, command and status codes, front-to-back job record.
// ----------------------------------------------------------------------------
package rfc_ecs_pkg;

  localparam int BUCKETS            = 1024;
  localparam int ENTRIES            = 4096;
  localparam int BITMAP_STORE_WORDS = 16384;
  localparam int MAX_WORDS          = 16;
  localparam int TABLES             = 13;

  localparam int BKT_W  = $clog2(BUCKETS);
  localparam int ENT_W  = $clog2(ENTRIES);
  localparam int EPTR_W = ENT_W + 1;
  localparam int BMI_W  = $clog2(BITMAP_STORE_WORDS);
  localparam int BMC_W  = BMI_W + 1;
  localparam int WRD_W  = $clog2(MAX_WORDS);
  localparam int WCNT_W = WRD_W + 1;

  typedef enum logic [1:0] {
    CMD_WORD    = 2'd0,
    CMD_RESTART = 2'd1,
    CMD_CLEAR   = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_FOUND = 2'd0,
    ST_ADDED = 2'd1,
    ST_FULL  = 2'd2,
    ST_RSVD  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    JOB_LOOKUP  = 2'd0,
    JOB_RESTART = 2'd1,
    JOB_CLEAR   = 2'd2,
    JOB_NOP     = 2'd3
  } job_kind_t;

  // One job handed from the front to the back
  typedef struct packed {
    job_kind_t          kind;
    logic [3:0]         table_id;
    logic [63:0]        word;
    logic [WRD_W-1:0]   slot;
    logic               last;
    logic [WCNT_W-1:0]  n;
  } job_t;

  typedef enum logic [3:0] {
    B_IDLE, B_HEAD, B_HEAD_W, B_ENT, B_ENT_W, B_CMP, B_CMP_W, B_DEC,
    B_STORE, B_LINK, B_OUT, B_CLEAR, B_SUM
  } bstate_t;

endpackage

/* design/rfc_ecs_front.sv */
// ----------------------------------------------------------------------------
// rfc_ecs_front: input front end
// Accepts items, tracks the bitmap word position and emits one job per item.
// ----------------------------------------------------------------------------
module rfc_ecs_front (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [4:0]               words_in_use,
  input  logic                     valid,
  output logic                     ready,
  input  logic [1:0]               command,
  input  logic [63:0]              bitmap_word,
  input  logic [3:0]               table_id,
  output logic                     job_valid,
  input  logic                     job_ready,
  output rfc_ecs_pkg::job_t        job
);

  logic [rfc_ecs_pkg::WCNT_W-1:0] word_count;
  logic [rfc_ecs_pkg::WCNT_W-1:0] n_eff;
  logic [rfc_ecs_pkg::WCNT_W-1:0] pos;
  logic                           take;

  // Clamp the configured word count
  always_comb begin
    if (words_in_use == 5'd0) begin
      n_eff = rfc_ecs_pkg::WCNT_W'(1);
    end else if (32'(words_in_use) > rfc_ecs_pkg::MAX_WORDS) begin
      n_eff = rfc_ecs_pkg::WCNT_W'(rfc_ecs_pkg::MAX_WORDS);
    end else begin
      n_eff = rfc_ecs_pkg::WCNT_W'(words_in_use);
    end
    pos = (32'(word_count) >= rfc_ecs_pkg::MAX_WORDS) ? '0 : word_count;
  end

  assign ready = job_ready;
  assign job_valid = valid;
  assign take = valid && ready;

  // Classify the item into a job
  always_comb begin
    job.table_id = table_id;
    job.word     = bitmap_word;
    job.slot     = pos[rfc_ecs_pkg::WRD_W-1:0];
    job.n        = n_eff;
    job.last     = (pos + 1'b1) >= n_eff;
    unique case (rfc_ecs_pkg::cmd_t'(command))
      rfc_ecs_pkg::CMD_WORD:    job.kind = rfc_ecs_pkg::JOB_LOOKUP;
      rfc_ecs_pkg::CMD_RESTART: job.kind = rfc_ecs_pkg::JOB_RESTART;
      rfc_ecs_pkg::CMD_CLEAR:   job.kind = rfc_ecs_pkg::JOB_CLEAR;
      default:                  job.kind = rfc_ecs_pkg::JOB_NOP;
    endcase
  end

  // Advance the word position
  always_ff @(posedge clk) begin
    if (rst) begin
      word_count <= '0;
    end else if (take) begin
      if (command == rfc_ecs_pkg::CMD_CLEAR) begin
        word_count <= '0;
      end else if (command == rfc_ecs_pkg::CMD_WORD) begin
        word_count <= job.last ? '0 : pos + 1'b1;
      end
    end
  end

endmodule

/* design/rfc_ecs_queue.sv */
// ----------------------------------------------------------------------------
// rfc_ecs_queue: job queue
// Two-entry queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module rfc_ecs_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  rfc_ecs_pkg::job_t  in_job,
  output logic               out_valid,
  input  logic               out_ready,
  output rfc_ecs_pkg::job_t  out_job
);

  rfc_ecs_pkg::job_t slots [2];
  logic              wptr;
  logic              rptr;
  logic [1:0]        count;
  logic              push;
  logic              pop;

  assign in_ready  = count != 2'd2;
  assign out_valid = count != 2'd0;
  assign out_job   = slots[rptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  // Store pushed jobs
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= in_job;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop) rptr <= ~rptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("queue count overflow");
  assert property (@(posedge clk) disable iff (rst)
    (count == 2'd2 && !pop) |=> count == 2'd2)
    else $error("full queue lost a job");
  assert property (@(posedge clk) disable iff (rst)
    (count == 2'd0 && !push) |=> !out_valid)
    else $error("empty queue produced a job");

endmodule

/* design/rfc_ecs_back.sv */
// ----------------------------------------------------------------------------
// rfc_ecs_back: lookup and insert engine
// Holds the stores, walks bucket chains, compares bitmaps and adds entries.
// ----------------------------------------------------------------------------
module rfc_ecs_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               job_valid,
  output logic               job_ready,
  input  rfc_ecs_pkg::job_t  job,
  output logic               valid,
  input  logic               ready,
  output logic [11:0]        class_id,
  output logic [1:0]         status
);

  localparam int BKT_W  = rfc_ecs_pkg::BKT_W;
  localparam int ENT_W  = rfc_ecs_pkg::ENT_W;
  localparam int EPTR_W = rfc_ecs_pkg::EPTR_W;
  localparam int BMI_W  = rfc_ecs_pkg::BMI_W;
  localparam int BMC_W  = rfc_ecs_pkg::BMC_W;
  localparam int WRD_W  = rfc_ecs_pkg::WRD_W;
  localparam int WCNT_W = rfc_ecs_pkg::WCNT_W;
  localparam logic [EPTR_W-1:0] END_MARK = EPTR_W'(rfc_ecs_pkg::ENTRIES);

  // Memories
  logic [EPTR_W-1:0] head_mem [rfc_ecs_pkg::BUCKETS];
  logic [EPTR_W-1:0] next_mem [rfc_ecs_pkg::ENTRIES];
  logic [BMI_W-1:0]  bmi_mem  [rfc_ecs_pkg::ENTRIES];
  logic [3:0]        tbl_mem  [rfc_ecs_pkg::ENTRIES];
  logic [11:0]       cls_mem  [rfc_ecs_pkg::ENTRIES];
  logic [63:0]       bm_mem   [rfc_ecs_pkg::BITMAP_STORE_WORDS];
  logic [63:0]       pend     [rfc_ecs_pkg::MAX_WORDS];
  logic [11:0]       counters [rfc_ecs_pkg::TABLES];

  rfc_ecs_pkg::bstate_t state;
  rfc_ecs_pkg::bstate_t state_next;

  logic [EPTR_W-1:0] head_rd;
  logic [EPTR_W-1:0] next_rd;
  logic [BMI_W-1:0]  bmi_rd;
  logic [3:0]        tbl_rd;
  logic [11:0]       cls_rd;
  logic [63:0]       bm_rd;
  logic [63:0]       pend_rd;

  logic [63:0]       hash;
  logic [BKT_W-1:0]  bucket;
  logic [3:0]        tbl;
  logic [WCNT_W-1:0] n;
  logic [EPTR_W-1:0] idx;
  logic [EPTR_W:0]   steps;
  logic              shared;
  logic [BMI_W-1:0]  shared_idx;
  logic [WCNT_W-1:0] widx;
  logic              mismatch;
  logic [EPTR_W-1:0] entries_used;
  logic [BMC_W-1:0]  words_used;
  logic [BKT_W-1:0]  clr_addr;
  logic [11:0]       res_class;
  logic [1:0]        res_status;
  logic [BMC_W:0]    bm_addr_wide;
  logic [BMI_W-1:0]  bm_addr;
  logic              bm_beyond;
  logic              beyond_q;
  logic              full_q;
  logic              cmp_eq;

  // Job accepted only when idle and the output is free
  assign job_ready = (state == rfc_ecs_pkg::B_IDLE) && !valid;
  assign bm_addr_wide = {1'b0, 1'b0, bmi_rd} + (BMC_W+1)'(widx);
  assign bm_beyond = bm_addr_wide >= (BMC_W+1)'(rfc_ecs_pkg::BITMAP_STORE_WORDS);
  assign bm_addr = bm_addr_wide[BMI_W-1:0];
  assign cmp_eq = (beyond_q ? 64'd0 : bm_rd) == pend_rd;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      rfc_ecs_pkg::B_IDLE: begin
        if (job_valid && job_ready) begin
          priority case (job.kind)
            rfc_ecs_pkg::JOB_LOOKUP:
              state_next = !job.last ? rfc_ecs_pkg::B_IDLE :
                (32'(job.table_id) >= rfc_ecs_pkg::TABLES) ? rfc_ecs_pkg::B_OUT :
                (32'(job.slot) + 1 == 32'(job.n)) ? rfc_ecs_pkg::B_HEAD :
                rfc_ecs_pkg::B_SUM;
            rfc_ecs_pkg::JOB_CLEAR: state_next = rfc_ecs_pkg::B_CLEAR;
            default: state_next = rfc_ecs_pkg::B_IDLE;
          endcase
        end
      end
      rfc_ecs_pkg::B_CLEAR:
        if (clr_addr == BKT_W'(rfc_ecs_pkg::BUCKETS - 1)) state_next = rfc_ecs_pkg::B_IDLE;
      rfc_ecs_pkg::B_SUM:
        if (widx + 1'b1 == n) state_next = rfc_ecs_pkg::B_HEAD;
      rfc_ecs_pkg::B_HEAD:   state_next = rfc_ecs_pkg::B_HEAD_W;
      rfc_ecs_pkg::B_HEAD_W: state_next = rfc_ecs_pkg::B_ENT;
      rfc_ecs_pkg::B_ENT: begin
        if (idx >= END_MARK || 32'(steps) >= rfc_ecs_pkg::ENTRIES) begin
          state_next = rfc_ecs_pkg::B_DEC;
        end else begin
          state_next = rfc_ecs_pkg::B_ENT_W;
        end
      end
      rfc_ecs_pkg::B_ENT_W: begin
        if (shared) begin
          state_next = (bmi_rd == shared_idx && tbl_rd == tbl) ?
            rfc_ecs_pkg::B_IDLE : rfc_ecs_pkg::B_ENT;
        end else begin
          state_next = rfc_ecs_pkg::B_CMP;
        end
      end
      rfc_ecs_pkg::B_CMP: state_next = rfc_ecs_pkg::B_CMP_W;
      rfc_ecs_pkg::B_CMP_W: begin
        if (widx == n) begin
          state_next = (!mismatch && cmp_eq && tbl_rd == tbl) ?
            rfc_ecs_pkg::B_IDLE : rfc_ecs_pkg::B_ENT;
        end else begin
          state_next = rfc_ecs_pkg::B_CMP;
        end
      end
      rfc_ecs_pkg::B_DEC: state_next = rfc_ecs_pkg::B_STORE;
      rfc_ecs_pkg::B_STORE:
        if (full_q || shared || widx == n) state_next = rfc_ecs_pkg::B_LINK;
      rfc_ecs_pkg::B_LINK: state_next = rfc_ecs_pkg::B_OUT;
      rfc_ecs_pkg::B_OUT:  state_next = rfc_ecs_pkg::B_IDLE;
      default:             state_next = rfc_ecs_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rfc_ecs_pkg::B_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Memory reads, registered
  always_ff @(posedge clk) begin
    head_rd <= head_mem[bucket];
    next_rd <= next_mem[idx[ENT_W-1:0]];
    bmi_rd  <= bmi_mem[idx[ENT_W-1:0]];
    tbl_rd  <= tbl_mem[idx[ENT_W-1:0]];
    cls_rd  <= cls_mem[idx[ENT_W-1:0]];
    bm_rd   <= bm_mem[bm_addr];
    pend_rd <= pend[widx[WRD_W-1:0]];
    beyond_q <= bm_beyond;
  end

  // Pending bitmap and bitmap store writes
  always_ff @(posedge clk) begin
    if (state == rfc_ecs_pkg::B_IDLE && job_valid && job_ready &&
        job.kind == rfc_ecs_pkg::JOB_LOOKUP) begin
      pend[job.slot] <= job.word;
    end
    if (state == rfc_ecs_pkg::B_STORE && !full_q && !shared && widx != n) begin
      bm_mem[words_used[BMI_W-1:0] + BMI_W'(widx)] <= pend[widx[WRD_W-1:0]];
    end
  end

  // Head and entry writes
  always_ff @(posedge clk) begin
    if (state == rfc_ecs_pkg::B_CLEAR) begin
      head_mem[clr_addr] <= END_MARK;
    end else if (state == rfc_ecs_pkg::B_LINK && !full_q) begin
      head_mem[bucket] <= entries_used;
    end
    if (state == rfc_ecs_pkg::B_LINK && !full_q) begin
      next_mem[entries_used[ENT_W-1:0]] <= head_rd;
      bmi_mem[entries_used[ENT_W-1:0]]  <= shared ? shared_idx : words_used[BMI_W-1:0];
      tbl_mem[entries_used[ENT_W-1:0]]  <= tbl;
      cls_mem[entries_used[ENT_W-1:0]]  <= counters[tbl];
    end
  end

  // Walk, compare and bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      entries_used <= '0;
      words_used   <= '0;
      clr_addr     <= '0;
      valid        <= 1'b0;
      hash         <= '0;
      for (int i = 0; i < rfc_ecs_pkg::TABLES; i++) counters[i] <= '0;
    end else begin
      if (valid && ready) valid <= 1'b0;
      unique case (state)
        rfc_ecs_pkg::B_IDLE: begin
          if (job_valid && job_ready) begin
            priority case (job.kind)
              rfc_ecs_pkg::JOB_LOOKUP: begin
                tbl <= job.table_id;
                n   <= job.n;
                res_class  <= '0;
                res_status <= rfc_ecs_pkg::ST_FULL;
                if (job.last) begin
                  hash   <= '0;
                  bucket <= BKT_W'(hash + job.word);
                end else begin
                  hash <= (job.slot == '0) ? job.word : hash + job.word;
                end
                if (job.slot == '0 && job.last) bucket <= BKT_W'(job.word);
                shared <= 1'b0;
                steps  <= '0;
                widx   <= '0;
              end
              rfc_ecs_pkg::JOB_RESTART:
                if (32'(job.table_id) < rfc_ecs_pkg::TABLES) counters[job.table_id] <= '0;
              rfc_ecs_pkg::JOB_CLEAR: begin
                clr_addr <= '0;
                entries_used <= '0;
                words_used <= '0;
              end
              default: ;
            endcase
          end
        end
        rfc_ecs_pkg::B_CLEAR: clr_addr <= clr_addr + 1'b1;
        // Re-sum the first n pending words when the bitmap ran past n
        rfc_ecs_pkg::B_SUM: begin
          widx <= widx + 1'b1;
          if (widx + 1'b1 == n) begin
            bucket <= BKT_W'(hash + pend[widx[WRD_W-1:0]]);
            hash   <= '0;
          end else begin
            hash <= hash + pend[widx[WRD_W-1:0]];
          end
        end
        rfc_ecs_pkg::B_HEAD: ;
        rfc_ecs_pkg::B_HEAD_W: idx <= head_rd;
        rfc_ecs_pkg::B_ENT: begin
          widx <= '0;
          mismatch <= 1'b0;
        end
        rfc_ecs_pkg::B_ENT_W: begin
          if (shared) begin
            if (bmi_rd == shared_idx && tbl_rd == tbl) begin
              res_class  <= cls_rd;
              res_status <= rfc_ecs_pkg::ST_FOUND;
              valid      <= 1'b1;
            end
            idx   <= next_rd;
            steps <= steps + 1'b1;
          end
        end
        rfc_ecs_pkg::B_CMP: widx <= widx + 1'b1;
        rfc_ecs_pkg::B_CMP_W: begin
          if (!cmp_eq) mismatch <= 1'b1;
          if (widx == n) begin
            if (!mismatch && cmp_eq) begin
              if (tbl_rd == tbl) begin
                res_class  <= cls_rd;
                res_status <= rfc_ecs_pkg::ST_FOUND;
                valid      <= 1'b1;
              end else begin
                shared     <= 1'b1;
                shared_idx <= bmi_rd;
              end
            end
            idx   <= next_rd;
            steps <= steps + 1'b1;
            widx  <= '0;
          end
        end
        rfc_ecs_pkg::B_DEC: begin
          widx <= '0;
          full_q <= (32'(entries_used) + 1 >= rfc_ecs_pkg::ENTRIES) ||
                    (!shared && (32'(words_used) + 32'(n) >=
                                 rfc_ecs_pkg::BITMAP_STORE_WORDS));
        end
        rfc_ecs_pkg::B_STORE:
          if (!full_q && !shared && widx != n) widx <= widx + 1'b1;
        rfc_ecs_pkg::B_LINK: begin
          if (!full_q) begin
            res_class  <= counters[tbl];
            res_status <= rfc_ecs_pkg::ST_ADDED;
            counters[tbl] <= counters[tbl] + 1'b1;
            entries_used <= entries_used + 1'b1;
            if (!shared) words_used <= words_used + BMC_W'(n);
          end
        end
        rfc_ecs_pkg::B_OUT: valid <= 1'b1;
        default: ;
      endcase
    end
  end

  assign class_id = res_class;
  assign status   = res_status;

  assert property (@(posedge clk) disable iff (rst)
    valid && !ready |=> valid && $stable(class_id) && $stable(status))
    else $error("result changed while stalled");
  assert property (@(posedge clk) disable iff (rst)
    (state == rfc_ecs_pkg::B_LINK && !full_q) |=>
      entries_used == $past(entries_used) + 1'b1)
    else $error("entry count not advanced");
  assert property (@(posedge clk) disable iff (rst)
    valid |-> status != rfc_ecs_pkg::ST_RSVD)
    else $error("reserved status");

endmodule

/* design/rfc_equivalence_class_store.sv */
// ----------------------------------------------------------------------------
// rfc_equivalence_class_store: RFC equivalence-class table store
// Front end, job queue and lookup/insert back end.
// ----------------------------------------------------------------------------
// The last word of a bitmap starts a chain walk in the back end that visits
// the entries of its bucket and compares their stored words one at a time
// (single-port bitmap memory), and a new bitmap is written one word per cycle.
// A bitmap that ends past the configured word count, after that count was
// lowered mid-bitmap, first re-sums its words at one per cycle. After reset
// and after a clear command the back end sweeps the bucket heads before
// taking further jobs.
module rfc_equivalence_class_store (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [4:0]   cfg_wdata,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [1:0]   command,
  input  logic [63:0]  bitmap_word,
  input  logic [3:0]   table_id,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [11:0]  class_id,
  output logic [1:0]   status
);

  logic [4:0]        words_in_use;
  logic              fq_valid;
  logic              fq_ready;
  rfc_ecs_pkg::job_t fq_job;
  logic              qb_valid;
  logic              qb_ready;
  rfc_ecs_pkg::job_t qb_job;

  // Hold the word-count register
  always_ff @(posedge clk) begin
    if (rst) begin
      words_in_use <= 5'd1;
    end else if (cfg_we) begin
      words_in_use <= cfg_wdata;
    end
  end

  rfc_ecs_front u_front (
    .clk, .rst, .words_in_use,
    .valid(in_valid), .ready(in_ready),
    .command, .bitmap_word, .table_id,
    .job_valid(fq_valid), .job_ready(fq_ready), .job(fq_job)
  );

  rfc_ecs_queue u_queue (
    .clk, .rst,
    .in_valid(fq_valid), .in_ready(fq_ready), .in_job(fq_job),
    .out_valid(qb_valid), .out_ready(qb_ready), .out_job(qb_job)
  );

  rfc_ecs_back u_back (
    .clk, .rst,
    .job_valid(qb_valid), .job_ready(qb_ready), .job(qb_job),
    .valid(out_valid), .ready(out_ready), .class_id, .status
  );

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the RFC equivalence-class store
// Drives bitmap words, restarts and clears through several bitmap widths.
// A built-in model of the store predicts each class id and status, and the
// results are checked in order under random stalls on both channels.
// ----------------------------------------------------------------------------
module tb;
  import rfc_ecs_pkg::*;

  typedef struct {
    logic [11:0] cls;
    status_t     st;
  } class_result_t;

  // Shadow copy of the store plus the queue of class results it predicts
  class class_scoreboard;
    int unsigned   heads [BUCKETS];
    int unsigned   nxt [ENTRIES];
    int unsigned   bm_base [ENTRIES];
    int unsigned   owner [ENTRIES];
    int unsigned   cls_of [ENTRIES];
    logic [63:0]   words [BITMAP_STORE_WORDS];
    int unsigned   counters [TABLES];
    int unsigned   n_entries;
    int unsigned   n_words;
    logic [63:0]   pend [MAX_WORDS];
    int unsigned   wc;
    int unsigned   width_reg;
    class_result_t due [$];
    int            fails;
    int            n_found, n_added, n_full;

    function void wipe();
      foreach (heads[b]) heads[b] = ENTRIES;
      n_entries = 0;
      n_words = 0;
      wc = 0;
    endfunction

    function void reset_all();
      width_reg = 1;
      foreach (counters[t]) counters[t] = 0;
      wipe();
      due.delete();
    endfunction

    function int unsigned eff_width();
      if (width_reg == 0) return 1;
      if (width_reg > MAX_WORDS) return MAX_WORDS;
      return width_reg;
    endfunction

    function bit same_words(int unsigned base, int unsigned n);
      for (int unsigned i = 0; i < n; i++)
        if (words[base + i] !== pend[i]) return 0;
      return 1;
    endfunction

    // Walk the bucket chain, then insert or share as the store does
    function class_result_t classify(int unsigned t, int unsigned n);
      class_result_t r;
      logic [63:0]   sum;
      int unsigned   bkt, idx, e, shared_base;
      bit            shared;
      r.cls = 0;
      r.st = ST_FULL;
      shared = 0;
      shared_base = 0;
      sum = 0;
      if (t >= TABLES) return r;
      for (int unsigned i = 0; i < n; i++) sum += pend[i];
      bkt = sum[BKT_W-1:0];
      idx = heads[bkt];
      for (int unsigned s = 0; idx < ENTRIES && s < ENTRIES; s++) begin
        if (shared) begin
          if (bm_base[idx] == shared_base && owner[idx] == t) begin
            r.cls = cls_of[idx];
            r.st = ST_FOUND;
            return r;
          end
        end else if (same_words(bm_base[idx], n)) begin
          if (owner[idx] == t) begin
            r.cls = cls_of[idx];
            r.st = ST_FOUND;
            return r;
          end
          shared = 1;
          shared_base = bm_base[idx];
        end
        idx = nxt[idx];
      end
      if (n_entries + 1 >= ENTRIES) return r;
      if (!shared && n_words + n >= BITMAP_STORE_WORDS) return r;
      e = n_entries;
      nxt[e] = heads[bkt];
      cls_of[e] = counters[t] & 12'hfff;
      counters[t] = (counters[t] + 1) & 12'hfff;
      owner[e] = t;
      heads[bkt] = e;
      n_entries = e + 1;
      if (shared) begin
        bm_base[e] = shared_base;
      end else begin
        bm_base[e] = n_words;
        for (int unsigned i = 0; i < n; i++) words[n_words + i] = pend[i];
        n_words += n;
      end
      r.cls = cls_of[e];
      r.st = ST_ADDED;
      return r;
    endfunction

    // Note one accepted input item
    function void note_item(cmd_t c, logic [63:0] w, logic [3:0] t);
      int unsigned n;
      class_result_t r;
      case (c)
        CMD_RESTART: begin
          if (t < TABLES) counters[t] = 0;
        end
        CMD_CLEAR: begin
          wipe();
        end
        CMD_WORD: begin
          n = eff_width();
          if (wc >= MAX_WORDS) wc = 0;
          pend[wc] = w;
          if (wc + 1 < n) begin
            wc++;
          end else begin
            wc = 0;
            r = classify(t, n);
            due.push_back(r);
          end
        end
        default: ;
      endcase
    endfunction

    // Check one accepted result against the oldest prediction
    function void check_result(logic [11:0] cls, logic [1:0] st);
      class_result_t r;
      if (due.size() == 0) begin
        $error("unexpected result class_id %0d status %0d", cls, st);
        fails++;
        return;
      end
      r = due.pop_front();
      if (cls !== r.cls) begin
        $error("class_id: expected %0d actual %0d", r.cls, cls);
        fails++;
      end
      if (st !== r.st) begin
        $error("status: expected %0d actual %0d", r.st, st);
        fails++;
      end
      case (r.st)
        ST_FOUND: n_found++;
        ST_ADDED: n_added++;
        default:  n_full++;
      endcase
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_we = 0;
  logic [4:0]  cfg_wdata = 0;
  logic        in_valid = 0;
  logic        in_ready;
  logic [1:0]  command = CMD_NONE;
  logic [63:0] bitmap_word = 0;
  logic [3:0]  table_id = 0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [11:0] class_id;
  logic [1:0]  status;

  class_scoreboard sb = new();
  int          hold_cycles = 0;
  bit          steady = 0;
  int          items_sent = 0;
  logic [63:0] bmp_set [6][MAX_WORDS];

  always #4 clk = ~clk;

  rfc_equivalence_class_store i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .command(command),
    .bitmap_word(bitmap_word), .table_id(table_id),
    .out_valid(out_valid), .out_ready(out_ready),
    .class_id(class_id), .status(status)
  );

  function automatic int gap_len();
    int p;
    p = $urandom_range(99);
    if (steady || p < 60) return 0;
    if (p < 90) return $urandom_range(3, 1);
    if (p < 98) return $urandom_range(20, 4);
    return $urandom_range(200, 50);
  endfunction

  // Offer one item after a random gap and hold it until accepted
  task automatic send_item(cmd_t c, logic [63:0] w, logic [3:0] t);
    int g;
    g = gap_len();
    @(negedge clk);
    if (g > 0) begin
      in_valid = 0;
      repeat (g) @(negedge clk);
    end
    command = c;
    bitmap_word = w;
    table_id = t;
    in_valid = 1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_item(c, w, t);
    items_sent++;
  endtask

  task automatic drain(int extra);
    @(negedge clk);
    in_valid = 0;
    while (sb.due.size() != 0) @(posedge clk);
    repeat (extra) @(negedge clk);
  endtask

  task automatic write_width(logic [4:0] v);
    @(negedge clk);
    cfg_we = 1;
    cfg_wdata = v;
    sb.width_reg = v;
    @(negedge clk);
    cfg_we = 0;
  endtask

  function automatic logic [63:0] rand_word();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [3:0] rand_table();
    if ($urandom_range(9) == 0) return $urandom_range(15, TABLES);
    return $urandom_range(TABLES - 1);
  endfunction

  // Send one bitmap: mostly from a small recurring set, sometimes fresh
  task automatic send_bitmap();
    int unsigned n, k;
    bit          fresh;
    logic [3:0]  t;
    n = sb.eff_width();
    k = $urandom_range(5);
    fresh = ($urandom_range(3) == 0);
    t = rand_table();
    for (int unsigned i = 0; i < n; i++) begin
      if (n > 1 && $urandom_range(29) == 0)
        send_item($urandom_range(1) ? CMD_RESTART : CMD_NONE, rand_word(), rand_table());
      send_item(CMD_WORD, fresh ? rand_word() : bmp_set[k][i], t);
    end
  endtask

  task automatic random_phase(int count);
    int p;
    foreach (bmp_set[k, i]) bmp_set[k][i] = rand_word();
    foreach (bmp_set[0][i]) bmp_set[0][i] = '0;
    foreach (bmp_set[1][i]) bmp_set[1][i] = '1;
    while (count > 0) begin
      p = $urandom_range(99);
      if (p < 88) begin
        send_bitmap();
        count -= sb.eff_width();
      end else begin
        if (p < 94) send_item(CMD_RESTART, rand_word(), $urandom_range(15));
        else if (p < 97) send_item(CMD_CLEAR, rand_word(), $urandom_range(15));
        else send_item(CMD_NONE, rand_word(), $urandom_range(15));
        count--;
      end
    end
  endtask

  // Change the bitmap width on an emptied store
  task automatic next_setting(logic [4:0] v);
    send_item(CMD_CLEAR, '0, '0);
    drain(1500);
    write_width(v);
  endtask

  // Receiver: random stalls, plus a long hold-off on request
  initial begin
    int g;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_ready = 0;
        hold_cycles--;
      end else begin
        g = gap_len();
        if (g > 0) begin
          out_ready = 0;
          repeat (g - 1) @(negedge clk);
          @(negedge clk);
        end
        out_ready = 1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(class_id, status);
  end

  initial begin
    #50_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    sb.reset_all();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Directed: add, find, share across tables, bad table, restart, clear
    steady = 1;
    send_item(CMD_WORD, '0, 4'd0);
    send_item(CMD_WORD, '0, 4'd0);
    send_item(CMD_WORD, '0, 4'd1);
    send_item(CMD_WORD, '1, 4'd12);
    send_item(CMD_WORD, '1, 4'd15);
    send_item(CMD_WORD, 64'd1024, 4'd0);
    send_item(CMD_RESTART, '0, 4'd0);
    send_item(CMD_WORD, 64'h8000_0000_0000_0000, 4'd0);
    send_item(CMD_WORD, 64'd1024, 4'd0);
    send_item(CMD_RESTART, '0, 4'd14);
    send_item(CMD_NONE, '1, 4'd3);
    send_item(CMD_CLEAR, '0, 4'd0);
    send_item(CMD_WORD, '0, 4'd0);
    send_item(CMD_WORD, '1, 4'd13);
    steady = 0;
    drain(1500);

    // Width 0 acts as one word; long receiver hold-off fills the block
    write_width(5'd0);
    hold_cycles = 3000;
    random_phase(250);
    next_setting(5'd31);
    random_phase(300);
    next_setting(5'd2);
    steady = 1;
    random_phase(150);
    steady = 0;
    next_setting(5'd5);
    random_phase(250);
    next_setting(5'd17);
    random_phase(300);
    next_setting(5'd3);
    random_phase(250);

    drain(1500);
    $display("run: %0d items, %0d found, %0d added, %0d refused, widths 1..16",
             items_sent, sb.n_found, sb.n_added, sb.n_full);
    $display("run: table sharing, restarts, clears, out-of-range tables, stalls");
    if (sb.fails == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
